FILE: src/scr_pkg.sv
package scr_pkg;

  localparam int unsigned MAX_LISTS_DEF    = 16;
  localparam int unsigned MAX_PER_LIST_DEF = 256;

  localparam int unsigned CFG_W = 5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [3:0]         list_index;
    logic signed [31:0] element_value;
    logic               last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [1:0]         status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic cmp;
    logic eval;
    logic emit;
  } scr_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic last_acc;
    logic err;
    logic scan_last;
    logic exhausted;
    logic out_busy;
  } scr_sts_t;

endpackage

FILE: src/scr_if.sv
interface scr_in_if;
  import scr_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scr_out_if;
  import scr_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/scr_ram.sv
module scr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/scr_ctrl.sv
module scr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  scr_pkg::scr_sts_t sts,
  output scr_pkg::scr_cmd_t cmd
);
  import scr_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_CHECK = 6'b000010,
    S_RD    = 6'b000100,
    S_CMP   = 6'b001000,
    S_EVAL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:  if (sts.last_acc) state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.err ? S_DONE : S_RD;
      S_RD:    state_nxt = S_CMP;
      S_CMP:   state_nxt = sts.scan_last ? S_EVAL : S_RD;
      S_EVAL:  state_nxt = sts.exhausted ? S_DONE : S_RD;
      S_DONE:  if (!sts.out_busy) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.load  = (state_r == S_LOAD);
    cmd.check = (state_r == S_CHECK);
    cmd.rd    = (state_r == S_RD);
    cmd.cmp   = (state_r == S_CMP);
    cmd.eval  = (state_r == S_EVAL);
    cmd.emit  = (state_r == S_DONE) && !sts.out_busy;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $past(state_r == S_RD))
    else $error("compare without a preceding read");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_LOAD))
    else $error("emit did not return to load");
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("commands not exclusive");

endmodule

FILE: src/scr_dp.sv
module scr_dp #(
  parameter int unsigned MAX_LISTS    = scr_pkg::MAX_LISTS_DEF,
  parameter int unsigned MAX_PER_LIST = scr_pkg::MAX_PER_LIST_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [scr_pkg::CFG_W-1:0] cfg_wdata,
  scr_in_if.sink                   in_ch,
  scr_out_if.source                out_ch,
  input  scr_pkg::scr_cmd_t        cmd,
  output scr_pkg::scr_sts_t        sts
);
  import scr_pkg::*;

  localparam int unsigned LW    = $clog2(MAX_LISTS);
  localparam int unsigned LW1   = $clog2(MAX_LISTS + 1);
  localparam int unsigned PW    = (MAX_PER_LIST > 1) ? $clog2(MAX_PER_LIST) : 1;
  localparam int unsigned CW    = $clog2(MAX_PER_LIST + 1);
  localparam int unsigned DEPTH = MAX_LISTS * (2 ** PW);
  localparam int unsigned AW    = LW + PW;

  logic [CFG_W-1:0]   cfg_r;
  logic [CW-1:0]      len_r  [MAX_LISTS];
  logic [PW-1:0]      head_r [MAX_LISTS];
  logic               ovf_r;
  logic [LW-1:0]      scan_idx_r;
  logic signed [31:0] min_val_r;
  logic [LW-1:0]      min_idx_r;
  logic signed [31:0] rmax_r;
  logic [32:0]        best_span_r;
  logic signed [31:0] best_low_r;
  logic signed [31:0] best_high_r;
  logic               out_valid_r;
  out_word_t          out_r;

  logic [LW1-1:0]     k_eff;
  logic               in_fire;
  logic               ld_ok;
  logic [LW-1:0]      ld_list;
  logic               ld_full;
  logic               empty;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;
  logic signed [31:0] rd_val;
  logic [32:0]        span;
  logic               exhausted;

  always_comb begin
    if (cfg_r == '0) begin
      k_eff = LW1'(1);
    end else if (32'(cfg_r) > MAX_LISTS) begin
      k_eff = LW1'(MAX_LISTS);
    end else begin
      k_eff = LW1'(cfg_r);
    end
  end

  assign in_ch.ready = cmd.load;
  assign in_fire     = in_ch.valid && cmd.load;
  assign ld_ok       = 32'(in_ch.data.list_index) < MAX_LISTS;
  assign ld_list     = LW'(32'(in_ch.data.list_index));
  assign ld_full     = 32'(len_r[ld_list]) >= MAX_PER_LIST;
  assign we          = in_fire && ld_ok && !ld_full;
  assign waddr       = {ld_list, len_r[ld_list][PW-1:0]};
  assign raddr       = {scan_idx_r, head_r[scan_idx_r]};
  assign rd_val      = $signed(rdata);

  always_comb begin
    empty = 1'b0;
    for (int i = 0; i < MAX_LISTS; i++) begin
      if (LW1'(i) < k_eff && len_r[i] == '0) begin
        empty = 1'b1;
      end
    end
  end

  assign span      = {rmax_r[31], rmax_r} - {min_val_r[31], min_val_r};
  assign exhausted = (CW + 1)'(head_r[min_idx_r]) + (CW + 1)'(1)
                     >= (CW + 1)'(len_r[min_idx_r]);

  always_comb begin
    sts           = '0;
    sts.last_acc  = in_fire && in_ch.data.last_item;
    sts.err       = ovf_r || empty;
    sts.scan_last = (LW1'(scan_idx_r) + LW1'(1)) == k_eff;
    sts.exhausted = exhausted;
    sts.out_busy  = out_valid_r;
  end

  scr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.data.element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(1);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Batch state: cleared by reset and again when the result is emitted.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int i = 0; i < MAX_LISTS; i++) begin
        len_r[i]  <= '0;
        head_r[i] <= '0;
      end
      ovf_r       <= 1'b0;
      rmax_r      <= 32'sh8000_0000;
      best_span_r <= '1;
      best_low_r  <= '0;
      best_high_r <= '0;
    end else begin
      if (in_fire && ld_ok) begin
        if (ld_full) begin
          ovf_r <= 1'b1;
        end else begin
          len_r[ld_list] <= len_r[ld_list] + CW'(1);
        end
      end
      // Folding every scanned head into the maximum equals tracking pushes.
      if (cmd.cmp && rd_val > rmax_r) begin
        rmax_r <= rd_val;
      end
      if (cmd.eval) begin
        if (span < best_span_r) begin
          best_span_r <= span;
          best_low_r  <= min_val_r;
          best_high_r <= rmax_r;
        end
        if (!exhausted) begin
          head_r[min_idx_r] <= head_r[min_idx_r] + PW'(1);
        end
      end
    end
  end

  // Ascending scan with strict less keeps the lower list on equal values.
  always_ff @(posedge clk) begin
    if (cmd.check || cmd.eval) begin
      scan_idx_r <= '0;
    end else if (cmd.cmp) begin
      scan_idx_r <= scan_idx_r + LW'(1);
    end
    if (cmd.cmp && (scan_idx_r == '0 || rd_val < min_val_r)) begin
      min_val_r <= rd_val;
      min_idx_r <= scan_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (ovf_r) begin
        out_r <= '{range_low: '0, range_high: '0, status: STATUS_OVERFLOW};
      end else if (empty) begin
        out_r <= '{range_low: '0, range_high: '0, status: STATUS_EMPTY};
      end else begin
        out_r <= '{range_low: best_low_r, range_high: best_high_r, status: STATUS_OK};
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval |-> (rmax_r >= min_val_r))
    else $error("running maximum below popped minimum");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (32'(head_r[scan_idx_r]) < 32'(len_r[scan_idx_r])))
    else $error("head read past list end");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("result appeared without emit");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (len_r[0] == '0 && !ovf_r))
    else $error("batch not cleared after result");

endmodule

FILE: src/smallest_covering_range_k_lists.sv
// Channel   Dir  Word                                          Handshake
// in_ch     in   list_index, element_value, last_item          valid/ready
// out_ch    out  range_low, range_high, status                 valid/ready
// cfg       in   lists_in_use                                  cfg_we, no stall
//
// Elements load one per cycle into the element memory while input is not stalled.
// After the last word there is a check state; each pop then reads the k list
// heads through the memory read port, a read state and a compare state per head,
// then an eval state; after the last pop, the result is emitted.
// An error status skips the search: the check state leads straight to the emit.
// Reset is synchronous active low and clears list lengths, heads and output valid.
// Input is stalled during the search, and at the end of a batch while the previous
// result still waits on the output.
module smallest_covering_range_k_lists #(
  parameter int unsigned MAX_LISTS    = scr_pkg::MAX_LISTS_DEF,
  parameter int unsigned MAX_PER_LIST = scr_pkg::MAX_PER_LIST_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [scr_pkg::CFG_W-1:0] cfg_wdata,
  scr_in_if.sink                    in_ch,
  scr_out_if.source                 out_ch
);
  import scr_pkg::*;

  scr_cmd_t cmd;
  scr_sts_t sts;

  scr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  scr_dp #(
    .MAX_LISTS    (MAX_LISTS),
    .MAX_PER_LIST (MAX_PER_LIST)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
